// File: rtl/assert_macros.svh
// Assertion macros used by the checker file tkss_checker.sv.
// No dependencies; expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

// File: rtl/tkss_pkg.sv
// Package for the top-k score selector: widths, register map, cell types.
// No dependencies.
`default_nettype none

package tkss_pkg;

  localparam int MAX_TOP     = 8;
  localparam int MAX_CLASSES = 1024;

  localparam int SCORE_W  = 32;
  localparam int IDX_W    = 10;
  localparam int TOPN_W   = 4;
  localparam int CNT_W    = $clog2(MAX_TOP + 1);
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] REG_TOP_N = PADDR_W'(0);
  localparam logic [TOPN_W-1:0]  TOP_N_RST = TOPN_W'(1);

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [IDX_W-1:0]          index;
  } entry_t;

  typedef struct packed {
    logic ins;  // insert broadcast score
    logic shl;  // shift toward head
    logic clr;  // drop all entries
  } cell_ctrl_t;

  // top_n of zero counts as one, above MAX_TOP as MAX_TOP
  function automatic logic [CNT_W-1:0] clamp_top_n(input logic [TOPN_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_TOP) begin
      r = CNT_W'(MAX_TOP);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tkss_if.sv
// Valid/ready stream interfaces for scores in and ranks out.
// Depends on tkss_pkg.
`default_nettype none

interface tkss_in_if import tkss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      last_score;

  modport source (output valid, output score, output last_score, input ready);
  modport sink   (input valid, input score, input last_score, output ready);
  modport mon    (input valid, input score, input last_score, input ready);
endinterface

interface tkss_out_if import tkss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          class_index;
  logic signed [SCORE_W-1:0] ranked_score;
  logic                      last_rank;

  modport source (output valid, output class_index, output ranked_score,
                  output last_rank, input ready);
  modport sink   (input valid, input class_index, input ranked_score,
                  input last_rank, output ready);
  modport mon    (input valid, input class_index, input ranked_score,
                  input last_rank, input ready);
endinterface

`default_nettype wire

// File: rtl/tkss_cell.sv
// One compare-and-shift cell of the sorted top-k row.
// Depends on tkss_pkg.
`default_nettype none

module tkss_cell import tkss_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cell_ctrl_t                ctrl,
  input  wire logic signed [SCORE_W-1:0] new_score,
  input  wire logic [IDX_W-1:0]          new_index,
  input  wire entry_t                    prev_entry,
  input  wire logic                      prev_gt,
  input  wire entry_t                    next_entry,
  output entry_t                         entry,
  output logic                           gt
);

  // strictly greater only: ties keep the earlier index ahead
  assign gt = !entry.valid || ($signed(new_score) > $signed(entry.score));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctrl.clr) begin
      entry.valid <= 1'b0;
    end else if (ctrl.ins) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else if (gt) begin
        entry.valid <= 1'b1;
        entry.score <= new_score;
        entry.index <= new_index;
      end
    end else if (ctrl.shl) begin
      entry <= next_entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/top_k_score_selector_core.sv
// Top level of the top-k score selector: cell row, drain sequencer, APB register.
// Depends on tkss_pkg, tkss_if (tkss_in_if, tkss_out_if) and tkss_cell.
`default_nettype none

// Keeps the MAX_TOP highest signed Q16.16 scores of a class vector, sorted
// highest first, in a row of compare-and-shift cells. The class index of a
// score is its arrival position in the vector; equal scores rank the earlier
// index first. Scores are taken one per cycle while the block is filling.
// When the score marked last_score is accepted it is inserted like the rest,
// then the block drains min(top_n, scores seen) ranks out through the head
// cell, one per cycle as the sink takes them, the final one flagged with
// last_rank. No score is accepted while the drain runs. Class indices
// restart at zero with each vector and wrap past MAX_CLASSES. top_n sits
// at byte address 0 on the APB port (reset 1, zero counts as 1, values
// above MAX_TOP count as MAX_TOP) and is meant to be written while the
// block is idle; the value in force at the last score decides the count.
module top_k_score_selector_core import tkss_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  tkss_in_if.sink                 scores,
  tkss_out_if.source              ranks,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  typedef enum logic {S_FILL, S_DRAIN} state_t;

  state_t                    state;
  logic [TOPN_W-1:0]         top_n;
  logic [IDX_W-1:0]          next_index;
  logic [CNT_W-1:0]          left;       // ranks still allowed by top_n
  logic                      rank_valid;
  logic [IDX_W-1:0]          rank_index;
  logic signed [SCORE_W-1:0] rank_score;
  logic                      rank_last;

  entry_t     cell_e [MAX_TOP];
  entry_t     prev_e [MAX_TOP];
  entry_t     next_e [MAX_TOP];
  logic       gt_chain [MAX_TOP+1];
  cell_ctrl_t ctrl;

  logic accept_in;
  logic drain_go;
  logic final_rank;
  logic cfg_wr;

  // ---------------------------------------------------------------------------
  // Cell row. Insert: a cell takes its upstream neighbor when that one lost
  // the compare, else the new score when it wins. Drain: shift toward head.
  // ---------------------------------------------------------------------------
  assign gt_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_e[i] = '0;
    end else begin : g_body
      assign prev_e[i] = cell_e[i-1];
    end
    if (i == MAX_TOP - 1) begin : g_tail
      assign next_e[i] = '0;
    end else begin : g_inner
      assign next_e[i] = cell_e[i+1];
    end

    tkss_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_score  (scores.score),
      .new_index  (next_index),
      .prev_entry (prev_e[i]),
      .prev_gt    (gt_chain[i]),
      .next_entry (next_e[i]),
      .entry      (cell_e[i]),
      .gt         (gt_chain[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Handshake and control
  // ---------------------------------------------------------------------------
  assign scores.ready = (state == S_FILL);
  assign accept_in    = scores.valid && scores.ready;

  // output register free, or being emptied this cycle
  assign drain_go   = (state == S_DRAIN) && (!rank_valid || ranks.ready);
  // entries are packed at the head, so an empty second cell ends the vector
  assign final_rank = (left == CNT_W'(1)) || !next_e[0].valid;

  assign ctrl.ins = accept_in;
  assign ctrl.shl = drain_go && !final_rank;
  assign ctrl.clr = drain_go && final_rank;

  assign ranks.valid        = rank_valid;
  assign ranks.class_index  = rank_index;
  assign ranks.ranked_score = rank_score;
  assign ranks.last_rank    = rank_last;

  // APB: single register, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_TOP_N);
  assign prdata = PDATA_W'(top_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      top_n      <= TOP_N_RST;
      next_index <= '0;
      left       <= '0;
      rank_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        top_n <= pwdata[TOPN_W-1:0];
      end

      if (accept_in) begin
        if (scores.last_score) begin
          next_index <= '0;
        end else if (32'(next_index) == MAX_CLASSES - 1) begin
          next_index <= '0;
        end else begin
          next_index <= next_index + IDX_W'(1);
        end
      end

      if (drain_go) begin
        rank_valid <= 1'b1;
        rank_index <= cell_e[0].index;
        rank_score <= cell_e[0].score;
        rank_last  <= final_rank;
      end else if (ranks.ready) begin
        rank_valid <= 1'b0;
      end

      unique case (state)
        S_FILL: begin
          if (accept_in && scores.last_score) begin
            state <= S_DRAIN;
            left  <= clamp_top_n(top_n);
          end
        end
        S_DRAIN: begin
          if (drain_go) begin
            left <= left - CNT_W'(1);
            if (final_rank) begin
              state <= S_FILL;
            end
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/tkss_checker.sv
// Port-level checks for top_k_score_selector_core, bound to it below.
// Depends on tkss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tkss_checker import tkss_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      sc_valid,
  input wire logic                      sc_ready,
  input wire logic                      sc_last,
  input wire logic                      rk_valid,
  input wire logic                      rk_ready,
  input wire logic [IDX_W-1:0]          rk_index,
  input wire logic signed [SCORE_W-1:0] rk_score,
  input wire logic                      rk_last,
  input wire logic                      psel,
  input wire logic                      penable,
  input wire logic                      pwrite,
  input wire logic [PADDR_W-1:0]        paddr,
  input wire logic [PDATA_W-1:0]        pwdata,
  input wire logic [PDATA_W-1:0]        prdata
);

  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr == REG_TOP_N);

  // a stalled rank transaction holds
  `ASSERT_NEXT(a_rank_hold, rk_valid && !rk_ready, rk_valid)
  `ASSERT_NEXT(a_rank_stable, rk_valid && !rk_ready, $stable({rk_index, rk_score, rk_last}))
  // last score starts the drain, which blocks new scores
  `ASSERT_NEXT(a_drain_blocks, sc_valid && sc_ready && sc_last, !sc_ready)
  // register write is visible on the read bus next cycle
  `ASSERT_NEXT(a_cfg_readback, cfg_wr, prdata[TOPN_W-1:0] == $past(pwdata[TOPN_W-1:0]))

endmodule

bind top_k_score_selector_core tkss_checker u_tkss_checker (
  .clk      (clk),
  .rst      (rst),
  .sc_valid (scores.valid),
  .sc_ready (scores.ready),
  .sc_last  (scores.last_score),
  .rk_valid (ranks.valid),
  .rk_ready (ranks.ready),
  .rk_index (ranks.class_index),
  .rk_score (ranks.ranked_score),
  .rk_last  (ranks.last_rank),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

`default_nettype wire
